>>> hdl/bank_switch_mapper_with_irq_counter_unit_assert.svh
// Assertion macros for the bank switch mapper checker.
`ifndef BANK_SWITCH_MAPPER_WITH_IRQ_COUNTER_UNIT_ASSERT_SVH
`define BANK_SWITCH_MAPPER_WITH_IRQ_COUNTER_UNIT_ASSERT_SVH

// ante holds, next cycle cons holds
`define BSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// stalled output beat keeps its value
`define BSM_ASSERT_HOLD(lbl, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(sig))) else $error(msg);

`endif

>>> hdl/bsmirq_pkg.sv
// Shared types and constants for the bank switch mapper.
`default_nettype none
package bsmirq_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CPU   = 2'd2,
    ACT_PPU   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SLOT_L0 = 2'd0,
    SLOT_H0 = 2'd1,
    SLOT_L1 = 2'd2,
    SLOT_H1 = 2'd3
  } slot_e;

  typedef struct packed {
    logic  ok;
    slot_e slot;
  } slot_t;

  localparam logic [3:0] PAGE_PRG_FIRST  = 4'h8;
  localparam logic [3:0] PAGE_MISC       = 4'h9;
  localparam logic [3:0] PAGE_PRG_MIDDLE = 4'hA;
  localparam logic [3:0] PAGE_CHR_B      = 4'hB;
  localparam logic [3:0] PAGE_CHR_C      = 4'hC;
  localparam logic [3:0] PAGE_CHR_D      = 4'hD;
  localparam logic [3:0] PAGE_CHR_E      = 4'hE;
  localparam logic [3:0] PAGE_IRQ        = 4'hF;

  localparam logic [7:0]        PRG_LAST_RESET  = 8'd31;
  localparam logic [7:0]        COUNT_MAX       = 8'hFF;
  localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
  localparam logic signed [9:0] PRESCALE_STEP   = 10'sd3;

  function automatic slot_t slot_decode(logic [3:0] nib);
    slot_t s;
    s.ok   = 1'b1;
    s.slot = SLOT_L0;
    case (nib)
      4'h0: s.slot = SLOT_L0;
      4'h2, 4'h8: s.slot = SLOT_H0;
      4'h1, 4'h4: s.slot = SLOT_L1;
      4'h3, 4'hC: s.slot = SLOT_H1;
      default: s.ok = 1'b0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> hdl/bank_switch_mapper_with_irq_counter_unit.sv
// An accepted input beat gives its result beat in the next cycle.
// Throughput: one beat per cycle unless out_stall_i holds a result beat; state
// updates and the lookup share one logic level between the input port and the
// result register. in_stall_o rises only while a result beat is held by out_stall_i.
// Reset: async active low; banks, IRQ state cleared, prescaler 341, last bank 31.
`default_nettype none
module bank_switch_mapper_with_irq_counter_unit #(
  parameter int CHR_WINDOWS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          bank_o,
  output logic                irq_line_o,
  output logic [1:0]          mirroring_o
);
  import bsmirq_pkg::*;

  localparam int ChrIdxW = $clog2(CHR_WINDOWS);

  logic [7:0] prg_last_q;
  logic [4:0] prg_first_q, prg_first_d;
  logic [4:0] prg_middle_q, prg_middle_d;
  logic       swap_q, swap_d;
  logic [7:0] chr_q [CHR_WINDOWS];
  logic [7:0] chr_d [CHR_WINDOWS];
  logic [1:0] mirror_q, mirror_d;
  logic [7:0] reload_q, reload_d;
  logic [7:0] count_q, count_d;
  logic signed [9:0] presc_q, presc_d;
  logic       cycle_mode_q, cycle_mode_d;
  logic       irq_en_q, irq_en_d;
  logic       en_after_ack_q, en_after_ack_d;
  logic       pending_q, pending_d;

  logic       out_valid_q;
  logic [7:0] bank_q, bank_d;
  logic [1:0] mirror_out_q;
  logic       irq_out_q;

  logic              in_acc;
  action_e           act;
  logic [3:0]        page;
  slot_t             sd;
  logic              reg_hit;
  logic              clock_cnt;
  logic signed [9:0] presc_sub;
  logic [7:0]        second_last;
  logic [7:0]        prg_sel;
  logic [ChrIdxW-1:0] chr_widx;
  logic [1:0]        chr_page;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign act        = action_e'(action_i);
  assign page       = address_i[15:12];
  assign sd         = slot_decode(address_i[3:0]);
  assign reg_hit    = page[3] && (address_i[11:4] == 8'h00) && sd.ok;
  assign presc_sub  = presc_q - PRESCALE_STEP;
  assign second_last = prg_last_q - 8'd1;
  assign chr_page   = 2'(page - PAGE_CHR_B);
  assign chr_widx   = ChrIdxW'({chr_page, sd.slot[1]});

  always_comb begin
    case (address_i[14:13])
      2'd0: prg_sel = swap_q ? second_last : {3'b000, prg_first_q};
      2'd1: prg_sel = {3'b000, prg_middle_q};
      2'd2: prg_sel = swap_q ? {3'b000, prg_first_q} : second_last;
      default: prg_sel = prg_last_q;
    endcase
  end

  always_comb begin
    prg_first_d    = prg_first_q;
    prg_middle_d   = prg_middle_q;
    swap_d         = swap_q;
    chr_d          = chr_q;
    mirror_d       = mirror_q;
    reload_d       = reload_q;
    count_d        = count_q;
    presc_d        = presc_q;
    cycle_mode_d   = cycle_mode_q;
    irq_en_d       = irq_en_q;
    en_after_ack_d = en_after_ack_q;
    pending_d      = pending_q;
    bank_d         = 8'h00;
    clock_cnt      = 1'b0;

    if (in_acc) begin
      case (act)
        ACT_WRITE: begin
          if (reg_hit) begin
            case (page)
              PAGE_PRG_FIRST: prg_first_d = value_i[4:0];
              PAGE_MISC: begin
                if (!sd.slot[1]) begin
                  mirror_d = value_i[1:0];
                end else begin
                  swap_d = value_i[1];
                end
              end
              PAGE_PRG_MIDDLE: prg_middle_d = value_i[4:0];
              PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D, PAGE_CHR_E: begin
                if (sd.slot[0]) begin
                  chr_d[chr_widx] = {value_i[3:0], chr_q[chr_widx][3:0]};
                end else begin
                  chr_d[chr_widx] = {chr_q[chr_widx][7:4], value_i[3:0]};
                end
              end
              PAGE_IRQ: begin
                case (sd.slot)
                  SLOT_L0: reload_d = {reload_q[7:4], value_i[3:0]};
                  SLOT_H0: reload_d = {value_i[3:0], reload_q[3:0]};
                  SLOT_L1: begin
                    cycle_mode_d   = value_i[2];
                    irq_en_d       = value_i[1];
                    en_after_ack_d = value_i[0];
                    if (value_i[1]) begin
                      count_d = reload_q;
                      presc_d = PRESCALE_RELOAD;
                    end
                    pending_d = 1'b0;
                  end
                  default: begin
                    pending_d = 1'b0;
                    irq_en_d  = en_after_ack_q;
                  end
                endcase
              end
              default: ;
            endcase
          end
        end
        ACT_TICK: begin
          if (irq_en_q) begin
            if (cycle_mode_q) begin
              clock_cnt = 1'b1;
            end else begin
              presc_d = presc_sub;
              if (presc_sub <= 10'sd0) begin
                presc_d   = presc_sub + PRESCALE_RELOAD;
                clock_cnt = 1'b1;
              end
            end
          end
        end
        ACT_CPU: begin
          if (address_i[15]) begin
            bank_d = prg_sel & prg_last_q;
          end
        end
        ACT_PPU: begin
          if (address_i[15:13] == 3'b000) begin
            bank_d = chr_q[address_i[10 +: ChrIdxW]];
          end
        end
        default: ;
      endcase
    end

    if (clock_cnt) begin
      if (count_q == COUNT_MAX) begin
        count_d   = reload_q;
        pending_d = 1'b1;
      end else begin
        count_d = count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_last_q     <= PRG_LAST_RESET;
      prg_first_q    <= '0;
      prg_middle_q   <= '0;
      swap_q         <= 1'b0;
      for (int i = 0; i < CHR_WINDOWS; i++) begin
        chr_q[i] <= '0;
      end
      mirror_q       <= '0;
      reload_q       <= '0;
      count_q        <= '0;
      presc_q        <= PRESCALE_RELOAD;
      cycle_mode_q   <= 1'b0;
      irq_en_q       <= 1'b0;
      en_after_ack_q <= 1'b0;
      pending_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        prg_last_q <= cfg_wdata_i;
      end
      prg_first_q    <= prg_first_d;
      prg_middle_q   <= prg_middle_d;
      swap_q         <= swap_d;
      chr_q          <= chr_d;
      mirror_q       <= mirror_d;
      reload_q       <= reload_d;
      count_q        <= count_d;
      presc_q        <= presc_d;
      cycle_mode_q   <= cycle_mode_d;
      irq_en_q       <= irq_en_d;
      en_after_ack_q <= en_after_ack_d;
      pending_q      <= pending_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded per accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      bank_q       <= bank_d;
      irq_out_q    <= pending_d;
      mirror_out_q <= mirror_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bank_o      = bank_q;
  assign irq_line_o  = irq_out_q;
  assign mirroring_o = mirror_out_q;

endmodule
`default_nettype wire

>>> hdl/bsmirq_checker.sv
// Port-level checker for the bank switch mapper, bound to the top level.
`default_nettype none
`include "bank_switch_mapper_with_irq_counter_unit_assert.svh"
module bsmirq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [1:0]  action_i,
  input wire logic [15:0] address_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  bank_o,
  input wire logic        irq_line_o,
  input wire logic [1:0]  mirroring_o
);
  import bsmirq_pkg::*;

  logic acc;
  logic is_xlate;
  logic no_bank;

  assign acc      = in_valid_i && !in_stall_o;
  assign is_xlate = (action_i == ACT_CPU) || (action_i == ACT_PPU);
  assign no_bank  = (action_i == ACT_WRITE) || (action_i == ACT_TICK) ||
                    ((action_i == ACT_CPU) && !address_i[15]) ||
                    ((action_i == ACT_PPU) && (address_i[15:13] != 3'b000));

  `BSM_ASSERT_HOLD(a_out_hold, bank_o, "stalled result beat changed")
  `BSM_ASSERT_NEXT(a_one_cycle, acc, out_valid_o, "accepted beat gave no result next cycle")
  `BSM_ASSERT_NEXT(a_no_bank, acc && no_bank, bank_o == 8'h00, "bank nonzero for unmapped beat")
  `BSM_ASSERT_NEXT(a_xlate_keeps, acc && is_xlate && out_valid_o, (irq_line_o == $past(irq_line_o)) && (mirroring_o == $past(mirroring_o)), "translate changed IRQ or mirroring")

endmodule

bind bank_switch_mapper_with_irq_counter_unit bsmirq_checker u_bsmirq_checker (.*);
`default_nettype wire
